// ----- rtl/core/sstf_pkg.sv -----
// Shared types and constants for the SSTF request scheduler.
`default_nettype none

package sstf_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int SECTOR_W  = 48;
    localparam int PENDING_W = 6;
    localparam int STATUS_W  = 2;
    localparam int S_DATA_W  = 48;   // sector
    localparam int M_DATA_W  = 56;   // dispatched_sector, pending, pad

    localparam logic KIND_ADD      = 1'b0;
    localparam logic KIND_DISPATCH = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Datapath operation for the current cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ADD_FIRST,
        OP_INS_START,
        OP_INS_STEP,
        OP_INS_LAST,
        OP_DSP_CUR,
        OP_DSP_PREV,
        OP_DSP_NEXT,
        OP_DSP_SHIFT,
        OP_DSP_FIN,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t res;
    } dp_cmd_t;

    typedef struct packed {
        logic is_disp;
        logic empty;
        logic full;
        logic gt;          // entry being read is above the new sector
        logic idx_zero;
        logic has_next;
        logic shift_last;
        logic out_busy;
        logic cursor_ok;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/sstf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sstf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/sstf_dpath.sv -----
// Datapath: sorted sector table, count, cursor, walk index and result register.
`default_nettype none

module sstf_dpath
    import sstf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_kind,
    input  wire logic [SECTOR_W-1:0]  s_sector,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output logic      [STATUS_W-1:0]  m_status,
    output logic      [SECTOR_W-1:0]  m_sector,
    output logic      [PENDING_W-1:0] m_pending,
    input  wire dp_cmd_t              cmd,
    output dp_stat_t                  stat
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = CW + 1;

    logic [CW-1:0]       count_reg, count_next;
    logic [IW-1:0]       cursor_reg, cursor_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic                kind_reg;
    logic [SECTOR_W-1:0] sec_reg;
    logic [SECTOR_W-1:0] cur_reg;
    logic [SECTOR_W-1:0] dp_reg;
    logic                go_prev_reg, go_prev_next;
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [SECTOR_W-1:0] out_sector_reg;
    logic [PENDING_W-1:0] out_pending_reg;

    logic                we;
    logic [IW-1:0]       waddr, raddr;
    logic [SECTOR_W-1:0] wdata, rdata;
    logic [SECTOR_W-1:0] dn;
    logic                has_prev;
    logic [CW+PENDING_W-1:0] count_wide;

    sstf_ram #(
        .WIDTH(SECTOR_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign has_prev   = (cursor_reg != '0);
    assign dn         = rdata - cur_reg;
    assign count_wide = (CW + PENDING_W)'(count_reg);

    always_comb begin
        stat.is_disp    = (kind_reg == KIND_DISPATCH);
        stat.empty      = (count_reg == '0);
        stat.full       = (count_reg >= CW'(DEPTH));
        stat.gt         = (rdata > sec_reg);
        stat.idx_zero   = (idx_reg == '0);
        stat.has_next   = ((XW'(cursor_reg) + XW'(1)) < XW'(count_reg));
        stat.shift_last = ((XW'(idx_reg) + XW'(1)) == XW'(count_reg));
        stat.out_busy   = out_valid_reg && !m_tready;
        stat.cursor_ok  = (count_reg == '0) ? (cursor_reg == '0)
                                            : (CW'(cursor_reg) < count_reg);
    end

    always_comb begin
        we           = 1'b0;
        waddr        = idx_reg + IW'(1);
        wdata        = sec_reg;
        raddr        = idx_reg;
        count_next   = count_reg;
        cursor_next  = cursor_reg;
        idx_next     = idx_reg;
        go_prev_next = go_prev_reg;
        case (cmd.op)
            OP_ADD_FIRST: begin
                we          = 1'b1;
                waddr       = '0;
                count_next  = CW'(1);
                cursor_next = '0;
            end
            OP_INS_START: begin
                raddr    = IW'(count_reg - CW'(1));
                idx_next = IW'(count_reg - CW'(1));
            end
            OP_INS_STEP: begin
                we = 1'b1;
                if (rdata > sec_reg) begin
                    // move this entry up one slot and keep walking down
                    wdata    = rdata;
                    raddr    = idx_reg - IW'(1);
                    idx_next = idx_reg - IW'(1);
                end else begin
                    count_next = count_reg + CW'(1);
                    if (idx_reg < cursor_reg) begin
                        cursor_next = cursor_reg + IW'(1);
                    end
                end
            end
            OP_INS_LAST: begin
                we          = 1'b1;
                waddr       = '0;
                count_next  = count_reg + CW'(1);
                cursor_next = cursor_reg + IW'(1);
            end
            OP_DSP_CUR: begin
                raddr = cursor_reg;
            end
            OP_DSP_PREV: begin
                raddr = cursor_reg - IW'(1);
            end
            OP_DSP_NEXT: begin
                go_prev_next = has_prev;
                raddr        = cursor_reg + IW'(1);
                idx_next     = cursor_reg + IW'(1);
            end
            OP_DSP_SHIFT: begin
                we       = 1'b1;
                waddr    = idx_reg - IW'(1);
                wdata    = rdata;
                raddr    = idx_reg + IW'(1);
                idx_next = idx_reg + IW'(1);
                // first shifted entry is the following neighbor
                if ((idx_reg - IW'(1)) == cursor_reg && has_prev) begin
                    go_prev_next = (dp_reg < dn);
                end
            end
            OP_DSP_FIN: begin
                count_next = count_reg - CW'(1);
                if (count_reg == CW'(1)) begin
                    cursor_next = '0;
                end else if (go_prev_reg) begin
                    cursor_next = cursor_reg - IW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            if (cmd.op == OP_RESULT) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        go_prev_reg <= go_prev_next;
        if (cmd.op == OP_LOAD) begin
            kind_reg <= s_kind;
            sec_reg  <= s_sector;
        end
        if (cmd.op == OP_DSP_PREV) begin
            cur_reg <= rdata;
        end
        if (cmd.op == OP_DSP_NEXT) begin
            dp_reg <= cur_reg - rdata;
        end
        if (cmd.op == OP_RESULT) begin
            out_status_reg  <= cmd.res;
            out_sector_reg  <= (cmd.res == ST_DONE && kind_reg == KIND_DISPATCH)
                               ? cur_reg : '0;
            out_pending_reg <= count_wide[PENDING_W-1:0];
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign m_status  = out_status_reg;
    assign m_sector  = out_sector_reg;
    assign m_pending = out_pending_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sstf_ctrl.sv -----
// Controller FSM: sequences table walks for add and dispatch requests.
`default_nettype none

module sstf_ctrl
    import sstf_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output dp_cmd_t       cmd,
    input  wire dp_stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS,
        S_INS_LAST,
        S_DPREV,
        S_DNEXT,
        S_DSHIFT,
        S_DFIN,
        S_RES
    } state_t;

    state_t  state_reg, state_next;
    status_t res_reg, res_next;
    logic    ready_reg;

    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd.op     = OP_NONE;
        cmd.res    = res_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                res_next = ST_DONE;
                if (!stat.is_disp) begin
                    if (stat.full) begin
                        res_next   = ST_FULL;
                        state_next = S_RES;
                    end else if (stat.empty) begin
                        cmd.op     = OP_ADD_FIRST;
                        state_next = S_RES;
                    end else begin
                        cmd.op     = OP_INS_START;
                        state_next = S_INS;
                    end
                end else if (stat.empty) begin
                    res_next   = ST_EMPTY;
                    state_next = S_RES;
                end else begin
                    cmd.op     = OP_DSP_CUR;
                    state_next = S_DPREV;
                end
            end
            S_INS: begin
                cmd.op = OP_INS_STEP;
                if (!stat.gt) begin
                    state_next = S_RES;
                end else if (stat.idx_zero) begin
                    state_next = S_INS_LAST;
                end
            end
            S_INS_LAST: begin
                cmd.op     = OP_INS_LAST;
                state_next = S_RES;
            end
            S_DPREV: begin
                cmd.op     = OP_DSP_PREV;
                state_next = S_DNEXT;
            end
            S_DNEXT: begin
                cmd.op     = OP_DSP_NEXT;
                state_next = stat.has_next ? S_DSHIFT : S_DFIN;
            end
            S_DSHIFT: begin
                cmd.op = OP_DSP_SHIFT;
                if (stat.shift_last) begin
                    state_next = S_DFIN;
                end
            end
            S_DFIN: begin
                cmd.op     = OP_DSP_FIN;
                state_next = S_RES;
            end
            S_RES: begin
                if (!stat.out_busy) begin
                    cmd.op     = OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            res_reg   <= ST_DONE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign s_tready = ready_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sstf_request_scheduler.sv -----
// Top level of the SSTF request scheduler.
`default_nettype none

// Holds up to DEPTH pending sector addresses in ascending order in a single-port-write,
// registered-read RAM, with a cursor on the entry the next dispatch hands out. An add
// request (tuser = 0) inserts its sector by walking the table down from the top, one
// entry per cycle, moving larger entries up; a dispatch request (tuser = 1) returns the
// sector at the cursor, reads its two neighbors, closes the gap by walking the entries
// above it down one per cycle and moves the cursor to the nearer neighbor (the following
// one on a tie). Each request yields exactly one result: status in m_tuser, the
// dispatched sector and the new pending count in m_tdata. How long a request occupies
// the block is set by the RAM walk, one entry per cycle, over the held entries above the
// insert position for an add or above the cursor for a dispatch. A rejected add or an
// empty dispatch skips the walk. A new request is taken while the previous result is
// still waiting on m_tready.
module sstf_request_scheduler
    import sstf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // [47:0] sector
    input  wire logic                s_tuser,   // [0] kind
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata,   // [47:0] dispatched_sector, [53:48] pending
    output logic      [STATUS_W-1:0] m_tuser    // [1:0] status
);

    dp_cmd_t              cmd;
    dp_stat_t             stat;
    logic [SECTOR_W-1:0]  out_sector;
    logic [PENDING_W-1:0] out_pending;

    sstf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .cmd     (cmd),
        .stat    (stat)
    );

    sstf_dpath #(
        .DEPTH(DEPTH)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_kind   (s_tuser),
        .s_sector (s_tdata[SECTOR_W-1:0]),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_status (m_tuser),
        .m_sector (out_sector),
        .m_pending(out_pending),
        .cmd      (cmd),
        .stat     (stat)
    );

    assign m_tdata = {(M_DATA_W - SECTOR_W - PENDING_W)'(0), out_pending, out_sector};

    // A request is taken only from idle; the block is busy the cycle after.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("scheduler ready right after taking a request");

    // Cursor stays on a held entry (or zero when empty) between requests.
    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> stat.cursor_ok)
        else $error("cursor outside held entries");

    // Only defined status codes; rejected results (full or empty) carry a zero sector.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_DONE || m_tuser == ST_FULL || m_tuser == ST_EMPTY))
        else $error("undefined result status");

    a_reject_zero_sector: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_EMPTY) |-> m_tdata[47:0] == '0)
        else $error("rejected request returned a sector");

endmodule

`default_nettype wire
